// ===== src/tsde_pkg.sv =====
package tsde_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_BITS = 32;

  localparam int DIFF_W   = COORD_BITS + 1;       // edge vector component
  localparam int PROD_W   = 2 * DIFF_W;           // product of two components
  localparam int DET_W    = PROD_W + 1;           // difference of two products
  localparam int LO_W     = (DET_W + 1) / 2;      // low half of a magnitude
  localparam int HI_W     = DET_W - LO_W;         // high half of a magnitude
  localparam int SQ_W     = 2 * DET_W;            // square of a magnitude
  localparam int N_W      = SQ_W + 2;             // sum of four squares
  localparam int NUM_W    = N_W + FRAC_BITS;      // scaled dividend
  localparam int CAP_LOG2 = 60;                   // quotient cap is 2^60
  localparam int Q_W      = CAP_LOG2 + 2;         // quotient bits developed
  localparam int DS_W     = SQ_W + Q_W - 1;       // shifted divisor
  localparam int QC_W     = CAP_LOG2 + 1;         // capped quotient
  localparam int SUM_W    = QC_W + 1;
  localparam int ENERGY_W = 48;

  localparam int FRONT_STAGES = 8;
  localparam int BACK_STAGES  = 2;
  localparam int LATENCY      = FRONT_STAGES + Q_W + BACK_STAGES;

  localparam logic [QC_W-1:0]     QUOT_CAP   = QC_W'(1) << CAP_LOG2;
  localparam logic [SUM_W-1:0]    FOUR       = SUM_W'(4) << FRAC_BITS;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

  // one divider lane: partial remainder, shifted divisor, quotient so far
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DS_W-1:0]  ds;
    logic [Q_W-1:0]   q;
    logic             cap;
  } lane_t;

endpackage

// ===== src/tsde_front.sv =====
module tsde_front
  import tsde_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic signed [COORD_BITS-1:0] ref_x0_i,
  input  logic signed [COORD_BITS-1:0] ref_y0_i,
  input  logic signed [COORD_BITS-1:0] ref_x1_i,
  input  logic signed [COORD_BITS-1:0] ref_y1_i,
  input  logic signed [COORD_BITS-1:0] ref_x2_i,
  input  logic signed [COORD_BITS-1:0] ref_y2_i,
  input  logic signed [COORD_BITS-1:0] tgt_x0_i,
  input  logic signed [COORD_BITS-1:0] tgt_y0_i,
  input  logic signed [COORD_BITS-1:0] tgt_x1_i,
  input  logic signed [COORD_BITS-1:0] tgt_y1_i,
  input  logic signed [COORD_BITS-1:0] tgt_x2_i,
  input  logic signed [COORD_BITS-1:0] tgt_y2_i,
  output logic                         valid_o,
  output logic                         deg_o,
  output lane_t                        lane_r_o,
  output lane_t                        lane_t_o
);

  logic [FRONT_STAGES-1:0] vld_q;
  logic deg4_q, deg5_q, deg6_q, deg7_q, deg8_q;

  // s1: edge vectors a b c d (reference), e f g h (target)
  logic signed [DIFF_W-1:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
  // s2: products
  logic signed [PROD_W-1:0] pr_q [12];
  // s3: determinants and adjugate terms
  logic signed [DET_W-1:0] v_q [6];
  // s4: magnitudes
  logic [DET_W-1:0] m_q [6];
  // s5: partial products
  logic [2*HI_W-1:0]      hh_q [6];
  logic [HI_W+LO_W-1:0]   hl_q [6];
  logic [2*LO_W-1:0]      ll_q [6];
  // s6: squares
  logic [SQ_W-1:0] sq_q [6];
  // s7: numerator and divisors
  logic [N_W-1:0]  n_q;
  logic [SQ_W-1:0] dr_q, dt_q;
  lane_t lr_q, lt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FRONT_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= DIFF_W'(ref_x1_i) - DIFF_W'(ref_x0_i);
    c_q <= DIFF_W'(ref_y1_i) - DIFF_W'(ref_y0_i);
    b_q <= DIFF_W'(ref_x2_i) - DIFF_W'(ref_x0_i);
    d_q <= DIFF_W'(ref_y2_i) - DIFF_W'(ref_y0_i);
    e_q <= DIFF_W'(tgt_x1_i) - DIFF_W'(tgt_x0_i);
    g_q <= DIFF_W'(tgt_y1_i) - DIFF_W'(tgt_y0_i);
    f_q <= DIFF_W'(tgt_x2_i) - DIFF_W'(tgt_x0_i);
    h_q <= DIFF_W'(tgt_y2_i) - DIFF_W'(tgt_y0_i);

    pr_q[0]  <= a_q * d_q;  pr_q[1]  <= b_q * c_q;
    pr_q[2]  <= e_q * h_q;  pr_q[3]  <= f_q * g_q;
    pr_q[4]  <= e_q * d_q;  pr_q[5]  <= f_q * c_q;
    pr_q[6]  <= f_q * a_q;  pr_q[7]  <= e_q * b_q;
    pr_q[8]  <= g_q * d_q;  pr_q[9]  <= h_q * c_q;
    pr_q[10] <= h_q * a_q;  pr_q[11] <= g_q * b_q;

    // det(R), det(T), then the entries of T adj(R); those of R adj(T)
    // are the same four up to sign, so both norms share one numerator
    for (int i = 0; i < 6; i++) begin
      v_q[i] <= DET_W'(pr_q[2*i]) - DET_W'(pr_q[2*i+1]);
    end

    for (int i = 0; i < 6; i++) begin
      m_q[i] <= v_q[i][DET_W-1] ? DET_W'(-v_q[i]) : DET_W'(v_q[i]);
    end
    deg4_q <= (v_q[0] == '0) || (v_q[1] == '0);

    for (int i = 0; i < 6; i++) begin
      hh_q[i] <= m_q[i][DET_W-1:LO_W] * m_q[i][DET_W-1:LO_W];
      hl_q[i] <= m_q[i][DET_W-1:LO_W] * m_q[i][LO_W-1:0];
      ll_q[i] <= m_q[i][LO_W-1:0] * m_q[i][LO_W-1:0];
    end
    deg5_q <= deg4_q;

    for (int i = 0; i < 6; i++) begin
      sq_q[i] <= (SQ_W'(hh_q[i]) << (2*LO_W)) + (SQ_W'(hl_q[i]) << (LO_W+1))
                 + SQ_W'(ll_q[i]);
    end
    deg6_q <= deg5_q;

    n_q  <= N_W'(sq_q[2]) + N_W'(sq_q[3]) + N_W'(sq_q[4]) + N_W'(sq_q[5]);
    dr_q <= sq_q[0];
    dt_q <= sq_q[1];
    deg7_q <= deg6_q;

    // quotient of 2^Q_W or more is capped before the bit stages
    lr_q.rem <= {n_q, FRAC_BITS'(0)};
    lr_q.ds  <= {dr_q, (Q_W-1)'(0)};
    lr_q.q   <= '0;
    lr_q.cap <= {(DS_W+1-NUM_W)'(0), n_q, FRAC_BITS'(0)} >= {dr_q, Q_W'(0)};
    lt_q.rem <= {n_q, FRAC_BITS'(0)};
    lt_q.ds  <= {dt_q, (Q_W-1)'(0)};
    lt_q.q   <= '0;
    lt_q.cap <= {(DS_W+1-NUM_W)'(0), n_q, FRAC_BITS'(0)} >= {dt_q, Q_W'(0)};
    deg8_q <= deg7_q;
  end

  assign valid_o  = vld_q[FRONT_STAGES-1];
  assign deg_o    = deg8_q;
  assign lane_r_o = lr_q;
  assign lane_t_o = lt_q;

endmodule

// ===== src/tsde_div_stage.sv =====
module tsde_div_stage
  import tsde_pkg::*;
(
  input  logic  clk_i,
  input  lane_t lane_i,
  output lane_t lane_o
);

  lane_t lane_d, lane_q;
  logic  ge;

  always_comb begin
    ge         = {(DS_W-NUM_W)'(0), lane_i.rem} >= lane_i.ds;
    lane_d     = lane_i;
    lane_d.rem = ge ? lane_i.rem - lane_i.ds[NUM_W-1:0] : lane_i.rem;
    lane_d.q   = {lane_i.q[Q_W-2:0], ge};
    lane_d.ds  = lane_i.ds >> 1;
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

// ===== src/tsde_back.sv =====
module tsde_back
  import tsde_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic                deg_i,
  input  lane_t               lane_r_i,
  input  lane_t               lane_t_i,
  output logic                valid_o,
  output logic [ENERGY_W-1:0] energy_o,
  output logic                deg_o,
  output logic                sat_o
);

  logic [QC_W-1:0]     qr, qt;
  logic [SUM_W-1:0]    sum_q;
  logic                vld1_q, deg1_q;
  logic                vld2_q, deg2_q, sat2_q;
  logic [ENERGY_W-1:0] energy_q;
  logic [SUM_W-1:0]    diff;

  always_comb begin
    qr = (lane_r_i.cap || lane_r_i.q > Q_W'(QUOT_CAP)) ? QUOT_CAP : lane_r_i.q[QC_W-1:0];
    qt = (lane_t_i.cap || lane_t_i.q > Q_W'(QUOT_CAP)) ? QUOT_CAP : lane_t_i.q[QC_W-1:0];
    diff = sum_q - FOUR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= SUM_W'(qr) + SUM_W'(qt);
    deg1_q <= deg_i;

    deg2_q <= deg1_q;
    priority if (deg1_q) begin
      energy_q <= ENERGY_MAX;
      sat2_q   <= 1'b0;
    end else if (sum_q < FOUR) begin
      energy_q <= '0;
      sat2_q   <= 1'b0;
    end else if (diff > SUM_W'(ENERGY_MAX)) begin
      energy_q <= ENERGY_MAX;
      sat2_q   <= 1'b1;
    end else begin
      energy_q <= diff[ENERGY_W-1:0];
      sat2_q   <= 1'b0;
    end
  end

  assign valid_o  = vld2_q;
  assign energy_o = energy_q;
  assign deg_o    = deg2_q;
  assign sat_o    = sat2_q;

endmodule

// ===== src/triangle_symmetric_dirichlet_energy_unit.sv =====
// Symmetric Dirichlet energy of one triangle map, |J|^2 + |J^-1|^2 - 4,
// unsigned Q32.16. One item (a reference and a target triangle) is taken
// in every clock cycle; busy_o never rises. Each result appears on done_o
// after its start_i has passed the edge, product, square and sum stages,
// the two restoring dividers that develop one quotient bit per stage,
// and the capping, adding and clamping stages. The receiver must take
// every strobe; results are not held.
// degenerate_o marks a zero determinant (energy then reads all ones),
// saturated_o an energy clamped at all ones.
module triangle_symmetric_dirichlet_energy_unit
  import tsde_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] ref_x0_i,
  input  logic signed [COORD_BITS-1:0] ref_y0_i,
  input  logic signed [COORD_BITS-1:0] ref_x1_i,
  input  logic signed [COORD_BITS-1:0] ref_y1_i,
  input  logic signed [COORD_BITS-1:0] ref_x2_i,
  input  logic signed [COORD_BITS-1:0] ref_y2_i,
  input  logic signed [COORD_BITS-1:0] tgt_x0_i,
  input  logic signed [COORD_BITS-1:0] tgt_y0_i,
  input  logic signed [COORD_BITS-1:0] tgt_x1_i,
  input  logic signed [COORD_BITS-1:0] tgt_y1_i,
  input  logic signed [COORD_BITS-1:0] tgt_x2_i,
  input  logic signed [COORD_BITS-1:0] tgt_y2_i,
  output logic                         done_o,
  output logic [ENERGY_W-1:0]          energy_o,
  output logic                         degenerate_o,
  output logic                         saturated_o
);

  // pure feed-forward pipeline: never refuses an item
  assign busy_o = 1'b0;

  logic  f_vld, f_deg;
  lane_t lr [Q_W+1];
  lane_t lt [Q_W+1];

  tsde_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start_i),
    .ref_x0_i (ref_x0_i), .ref_y0_i (ref_y0_i),
    .ref_x1_i (ref_x1_i), .ref_y1_i (ref_y1_i),
    .ref_x2_i (ref_x2_i), .ref_y2_i (ref_y2_i),
    .tgt_x0_i (tgt_x0_i), .tgt_y0_i (tgt_y0_i),
    .tgt_x1_i (tgt_x1_i), .tgt_y1_i (tgt_y1_i),
    .tgt_x2_i (tgt_x2_i), .tgt_y2_i (tgt_y2_i),
    .valid_o  (f_vld),
    .deg_o    (f_deg),
    .lane_r_o (lr[0]),
    .lane_t_o (lt[0])
  );

  // divider bit stages, one quotient bit per stage, MSB first
  for (genvar k = 0; k < Q_W; k++) begin : g_div
    tsde_div_stage u_r (.clk_i(clk_i), .lane_i(lr[k]), .lane_o(lr[k+1]));
    tsde_div_stage u_t (.clk_i(clk_i), .lane_i(lt[k]), .lane_o(lt[k+1]));
  end

  // valid and degenerate flag ride alongside the divider lanes
  logic [Q_W-1:0] vld_q;
  logic [Q_W-1:0] deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Q_W-2:0], f_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    deg_q <= {deg_q[Q_W-2:0], f_deg};
  end

  tsde_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vld_q[Q_W-1]),
    .deg_i    (deg_q[Q_W-1]),
    .lane_r_i (lr[Q_W]),
    .lane_t_i (lt[Q_W]),
    .valid_o  (done_o),
    .energy_o (energy_o),
    .deg_o    (degenerate_o),
    .sat_o    (saturated_o)
  );

  // every accepted item comes out after the fixed latency
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LATENCY done_o) else $error("item lost in pipeline");

  a_no_invent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LATENCY)) else $error("result without item");

  a_deg_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> (energy_o == ENERGY_MAX && !saturated_o))
    else $error("degenerate result malformed");

endmodule
